// File: hw/rtl/clcd_pkg.sv
package clcd_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [6:0] ODD_ROW_BASE = 7'h40;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_RETURN  = 8'd13;
    localparam logic [3:0] NIBBLE_MASK  = 4'hF;

    localparam logic [5:0] COLUMNS_RESET = 6'd16;
    localparam logic       NIBBLE_RESET  = 1'b1;

    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_NIBBLE  = 1'b1;

    typedef enum logic [1:0] {
        MODE_TEXT  = 2'd0,
        MODE_GOTO  = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    typedef struct packed {
        logic [5:0] columns;
        logic       nibble_mode;
    } t_cfg;

    typedef struct packed {
        logic       is_data;
        logic [7:0] value;
    } t_qentry;

    typedef struct packed {
        logic    push;
        t_qentry entry;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// File: hw/rtl/clcd_if.sv
interface clcd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] char_code;
    logic [7:0] row;
    logic [6:0] col;

    modport source (output valid, output mode, output char_code, output row, output col,
                    input ready);
    modport sink (input valid, input mode, input char_code, input row, input col,
                  output ready);
endinterface

interface clcd_out_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic [7:0] bus_value;
    logic       last;

    modport source (output valid, output reg_select, output bus_value, output last,
                    input ready);
    modport sink (input valid, input reg_select, input bus_value, input last,
                  output ready);
endinterface

// File: hw/rtl/clcd_front.sv
module clcd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  clcd_pkg::t_cfg i_cfg,
    input  clcd_pkg::t_qstat i_qstat,
    clcd_in_if.sink        i_in,
    output clcd_pkg::t_push o_push
);
    import clcd_pkg::*;

    logic [7:0] r_row;
    logic [7:0] n_row;
    logic [7:0] w_target;
    logic [6:0] w_col;
    logic [6:0] w_addr;
    logic       w_goto;
    logic       w_accept;
    t_qentry    w_entry;
    logic       w_emit;

    assign i_in.ready = !i_qstat.full;
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        w_goto   = 1'b0;
        w_emit   = 1'b1;
        w_target = r_row;
        w_col    = 7'd0;
        n_row    = r_row;
        w_entry  = '{is_data: 1'b1, value: i_in.char_code};
        case (t_mode'(i_in.mode))
            MODE_TEXT: begin
                if (i_in.char_code == CHAR_NEWLINE) begin
                    w_goto   = 1'b1;
                    w_target = r_row + 8'd1;
                end else if (i_in.char_code == CHAR_RETURN) begin
                    w_goto = 1'b1;
                end
            end
            MODE_GOTO: begin
                w_goto   = 1'b1;
                w_target = i_in.row;
                w_col    = i_in.col;
            end
            MODE_CLEAR: begin
                n_row   = 8'd0;
                w_entry = '{is_data: 1'b0, value: CMD_CLEAR};
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
        w_addr = (w_target[0] ? ODD_ROW_BASE : 7'd0)
               + ((w_target > 8'd1) ? {1'b0, i_cfg.columns} : 7'd0)
               + w_col;
        if (w_goto) begin
            n_row   = w_target;
            w_entry = '{is_data: 1'b0, value: CMD_SET_ADDR | {1'b0, w_addr}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= 8'd0;
        end else if (w_accept) begin
            r_row <= n_row;
        end
    end

    assign o_push.push  = w_accept && w_emit;
    assign o_push.entry = w_entry;

endmodule

// File: hw/rtl/clcd_queue.sv
module clcd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  clcd_pkg::t_push   i_push,
    input  logic              i_pop,
    output clcd_pkg::t_qentry o_head,
    output clcd_pkg::t_qstat  o_qstat
);
    import clcd_pkg::*;

    t_qentry           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_qstat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign w_push = i_push.push && !o_qstat.full;
    assign w_pop  = i_pop && !o_qstat.empty;
    assign o_head = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: hw/rtl/clcd_back.sv
module clcd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  clcd_pkg::t_cfg    i_cfg,
    input  clcd_pkg::t_qentry i_head,
    input  clcd_pkg::t_qstat  i_qstat,
    output logic              o_pop,
    clcd_out_if.source        o_out
);
    import clcd_pkg::*;

    logic       r_valid;
    logic       r_rs;
    logic [7:0] r_bus;
    logic       r_last;
    logic       r_pend;
    logic       r_pend_rs;
    logic [3:0] r_pend_nib;
    logic       w_load;

    assign w_load = !r_valid || o_out.ready;
    assign o_pop  = w_load && !r_pend && !i_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (w_load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else if (!i_qstat.empty) begin
                r_valid <= 1'b1;
                r_pend  <= i_cfg.nibble_mode;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_pend) begin
                r_rs   <= r_pend_rs;
                r_bus  <= {4'd0, r_pend_nib};
                r_last <= 1'b1;
            end else begin
                r_rs       <= i_head.is_data;
                r_pend_rs  <= i_head.is_data;
                r_pend_nib <= i_head.value[3:0] & NIBBLE_MASK;
                if (i_cfg.nibble_mode) begin
                    r_bus  <= {4'd0, i_head.value[7:4]};
                    r_last <= 1'b0;
                end else begin
                    r_bus  <= i_head.value;
                    r_last <= 1'b1;
                end
            end
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.reg_select = r_rs;
    assign o_out.bus_value  = r_bus;
    assign o_out.last       = r_last;

endmodule

// File: hw/rtl/char_lcd_text_command_stream.sv
// Takes text characters, go-to and clear requests and turns them into
// character-LCD bus transfers, each with a register select flag and a last flag.
// A request is accepted in any cycle in which the two-entry queue between the
// front end and the bus driver has room; the first transfer passes through the
// queue and then the output register. In 4-bit mode every byte leaves as two
// transfers through the single output register; in 8-bit mode the rate is one
// request a cycle while ready stays high. Mode 3 is accepted and yields nothing.
// Columns and nibble mode sit at APB byte addresses 0 and 4 and should be
// written only while no transfer is pending.
module char_lcd_text_command_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    clcd_in_if.sink     i_in,
    clcd_out_if.source  o_out
);
    import clcd_pkg::*;

    t_cfg    r_cfg;
    t_push   w_push;
    t_qentry w_head;
    t_qstat  w_qstat;
    logic    w_pop;
    logic    w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.columns     <= COLUMNS_RESET;
            r_cfg.nibble_mode <= NIBBLE_RESET;
        end else if (w_wr) begin
            case (paddr[2])
                REG_COLUMNS: r_cfg.columns     <= pwdata[5:0];
                REG_NIBBLE:  r_cfg.nibble_mode <= pwdata[0];
                default:     r_cfg             <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_COLUMNS: prdata = {26'd0, r_cfg.columns};
            REG_NIBBLE:  prdata = {31'd0, r_cfg.nibble_mode};
            default:     prdata = 32'd0;
        endcase
    end

    clcd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_qstat (w_qstat),
        .i_in    (i_in),
        .o_push  (w_push)
    );

    clcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    clcd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

// File: hw/rtl/clcd_checker.sv
module clcd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_pready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_bus,
    input logic       i_out_last
);

    // A stalled transfer stays on the bus.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output transfer dropped while stalled");

    // The low nibble follows the high nibble without a gap.
    a_nibble_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=> i_out_valid)
        else $error("second nibble not ready after the first");

    // A transfer that is not last can only be a high nibble.
    a_nibble_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_last) |-> (i_out_bus[7:4] == 4'd0))
        else $error("nibble transfer has upper bits set");

    // Nothing leaves the block straight after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready low");

endmodule

bind char_lcd_text_command_stream clcd_checker u_clcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pready    (pready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_bus   (o_out.bus_value),
    .i_out_last  (o_out.last)
);
